/* src/npls_pkg.sv */
`default_nettype none

package npls_pkg;

   localparam int COORD_BITS       = 16;
   localparam int DIM_CFG_BITS     = 5;
   localparam int INDEX_BITS       = 10;
   localparam int DIST_BITS        = 36;

   localparam int MAX_POINTS_DEF     = 1024;
   localparam int MAX_DIMENSIONS_DEF = 16;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic                         func;
      logic signed [COORD_BITS-1:0] coordinate;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] nearest_index;
      logic                  found;
      logic [DIST_BITS-1:0]  distance_squared;
      logic                  store_full;
   } rsp_type;

endpackage

`default_nettype wire

/* src/nearest_point_linear_scan.sv */
`default_nettype none

// nearest-point store with a brute-force squared-distance search
//
// req channel: an input word is taken at a clock edge with start high and busy low.
// every word carries one coordinate; dimension_count words make one point. the func of
// the last word decides: add appends the point to the store, query searches the store.
// coordinate words are taken one per cycle while busy is low and give no response.
// rsp channel: rsp_valid is high for exactly one cycle per response; the receiver cannot
// stall it, so it must take every response word.
// - add on a full store: dropped, response with store_full set in the cycle after the word
// - query on an empty store: response with found low in the cycle after the word
// - query otherwise: busy through the scan and the pipeline drain, response at the edge
//   that drops busy; the scan reads one stored coordinate per cycle from the single
//   store read port, through a subtract, square, accumulate and compare pipeline
// csr channel: writes dimension_count (0 is taken as 1, values above the maximum as the
// maximum) and empties the store; csr_ready is low while a search runs.
// reset: store empty, dimension_count 1, no response pending; the store memory itself
// is not cleared, so no clearing pass is needed and the block is ready at once.

module nearest_point_linear_scan #(
   parameter int MAX_POINTS     = npls_pkg::MAX_POINTS_DEF,
   parameter int MAX_DIMENSIONS = npls_pkg::MAX_DIMENSIONS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire  npls_pkg::req_type              req_data,
   output logic                                 rsp_valid,
   output npls_pkg::rsp_type                    rsp_data,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [npls_pkg::DIM_CFG_BITS-1:0]    csr_data
);

   localparam int CB        = npls_pkg::COORD_BITS;
   localparam int PT_W      = $clog2(MAX_POINTS);
   localparam int CNT_W     = $clog2(MAX_POINTS + 1);
   localparam int DIM_W     = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
   localparam int DC_W      = $clog2(MAX_DIMENSIONS + 1);
   localparam int CFG_W     = (DC_W > npls_pkg::DIM_CFG_BITS) ? DC_W : npls_pkg::DIM_CFG_BITS;
   localparam int MEM_DEPTH = MAX_POINTS * (1 << DIM_W);
   localparam int SQ_W      = 2 * (CB + 1);
   localparam int SUM_W     = SQ_W + DC_W;
   localparam int DB        = npls_pkg::DIST_BITS;
   localparam int IB        = npls_pkg::INDEX_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_type;

   // control
   state_type               state_ff, state_in;
   logic [DC_W-1:0]         dim_ff, dim_in;
   logic [DIM_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PT_W-1:0]         scan_pt_ff, scan_pt_in;
   logic [DIM_W-1:0]        scan_dim_ff, scan_dim_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   npls_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   logic                    any_ff, any_in;

   // pipeline valids
   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff, done_valid_ff;

   // payload
   logic signed [CB-1:0]    qbuf_ff [MAX_DIMENSIONS];
   logic signed [CB-1:0]    mem [MEM_DEPTH];
   logic signed [CB-1:0]    rd_ff;
   logic signed [CB-1:0]    s1_q_ff;
   logic                    s1_first_ff, s1_last_ff, s2_first_ff, s2_last_ff;
   logic                    s3_first_ff, s3_last_ff;
   logic [PT_W-1:0]         s1_pt_ff, s2_pt_ff, s3_pt_ff, done_pt_ff;
   logic signed [CB:0]      diff_ff;
   logic signed [SQ_W-1:0]  sq_ff;
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic [SUM_W-1:0]        done_sum_ff;
   logic [SUM_W-1:0]        best_ff;
   logic [PT_W-1:0]         best_pt_ff;

   logic                    accept;
   logic                    csr_write;
   logic                    last_coord;
   logic                    store_has_room;
   logic                    mem_we;
   logic [PT_W+DIM_W-1:0]   wr_addr;
   logic [PT_W+DIM_W-1:0]   rd_addr;
   logic                    issue;
   logic                    pipe_empty;
   logic                    better;
   logic [CFG_W-1:0]        cfg_raw;
   logic [DC_W-1:0]         cfg_dim;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign accept         = start && !busy;
   assign csr_write      = csr_valid && csr_ready;
   assign last_coord     = (DC_W'(pos_ff) + DC_W'(1)) >= dim_ff;
   assign store_has_room = count_ff < CNT_W'(MAX_POINTS);
   // coordinates go straight into the next free slot; only an add that completes commits it
   assign mem_we         = accept && store_has_room;
   assign wr_addr        = {count_ff[PT_W-1:0], pos_ff};
   assign rd_addr        = {scan_pt_ff, scan_dim_ff};
   assign issue          = (state_ff == ST_SCAN);
   assign pipe_empty     = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff && !done_valid_ff;
   assign better         = !any_ff || (done_sum_ff < best_ff);

   assign cfg_raw = CFG_W'(csr_data);
   always_comb begin
      if (cfg_raw == '0) begin
         cfg_dim = DC_W'(1);
      end else if (cfg_raw > CFG_W'(MAX_DIMENSIONS)) begin
         cfg_dim = DC_W'(MAX_DIMENSIONS);
      end else begin
         cfg_dim = cfg_raw[DC_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      dim_in       = dim_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      scan_pt_in   = scan_pt_ff;
      scan_dim_in  = scan_dim_ff;
      any_in       = any_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;

      if (done_valid_ff && better) begin
         any_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!last_coord) begin
                  pos_in = pos_ff + DIM_W'(1);
               end else begin
                  pos_in = '0;
                  if (req_data.func == npls_pkg::FUNC_ADD) begin
                     if (store_has_room) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        rsp_valid_in           = 1'b1;
                        rsp_data_in.store_full = 1'b1;
                     end
                  end else if (count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in    = ST_SCAN;
                     scan_pt_in  = '0;
                     scan_dim_in = '0;
                     any_in      = 1'b0;
                  end
               end
            end
            if (csr_write) begin
               dim_in   = cfg_dim;
               count_in = '0;
               pos_in   = '0;
            end
         end
         ST_SCAN: begin
            if (DC_W'(scan_dim_ff) + DC_W'(1) >= dim_ff) begin
               scan_dim_in = '0;
               if (CNT_W'(scan_pt_ff) + CNT_W'(1) >= count_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  scan_pt_in = scan_pt_ff + PT_W'(1);
               end
            end else begin
               scan_dim_in = scan_dim_ff + DIM_W'(1);
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               state_in                     = ST_IDLE;
               rsp_valid_in                 = 1'b1;
               rsp_data_in.found            = 1'b1;
               rsp_data_in.nearest_index    = IB'(best_pt_ff);
               rsp_data_in.distance_squared = (|best_ff[SUM_W-1:DB]) ? '1 : best_ff[DB-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dim_ff        <= DC_W'(1);
         pos_ff        <= '0;
         count_ff      <= '0;
         scan_pt_ff    <= '0;
         scan_dim_ff   <= '0;
         any_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_data_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         done_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dim_ff        <= dim_in;
         pos_ff        <= pos_in;
         count_ff      <= count_in;
         scan_pt_ff    <= scan_pt_in;
         scan_dim_ff   <= scan_dim_in;
         any_ff        <= any_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
         s1_valid_ff   <= issue;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         done_valid_ff <= s3_valid_ff && s3_last_ff;
      end
   end

   // point store: one write port for loading, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_data.coordinate;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      if (s3_first_ff) begin
         acc_in = SUM_W'(sq_ff);
      end else begin
         acc_in = acc_ff + SUM_W'(sq_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         qbuf_ff[pos_ff] <= req_data.coordinate;
      end
      // read stage: query coordinate lines up with the store data
      s1_q_ff     <= qbuf_ff[scan_dim_ff];
      s1_first_ff <= (scan_dim_ff == '0);
      s1_last_ff  <= (DC_W'(scan_dim_ff) + DC_W'(1) >= dim_ff);
      s1_pt_ff    <= scan_pt_ff;
      // difference
      diff_ff     <= (CB + 1)'(rd_ff) - (CB + 1)'(s1_q_ff);
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_pt_ff    <= s1_pt_ff;
      // square of a sign-extended difference
      sq_ff       <= SQ_W'(diff_ff) * SQ_W'(diff_ff);
      s3_first_ff <= s2_first_ff;
      s3_last_ff  <= s2_last_ff;
      s3_pt_ff    <= s2_pt_ff;
      // accumulate
      if (s3_valid_ff) begin
         acc_ff <= acc_in;
      end
      done_sum_ff <= acc_in;
      done_pt_ff  <= s3_pt_ff;
      // compare, first strictly smaller distance wins
      if (done_valid_ff && better) begin
         best_ff    <= done_sum_ff;
         best_pt_ff <= done_pt_ff;
      end
   end

   a_pos_in_range : assert property (@(posedge clock) disable iff (reset)
      DC_W'(pos_ff) < dim_ff)
      else $error("coordinate position beyond dimension count");

   a_dim_in_range : assert property (@(posedge clock) disable iff (reset)
      (dim_ff != '0) && (dim_ff <= DC_W'(MAX_DIMENSIONS)))
      else $error("dimension count out of range");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store size");

   a_no_write_in_scan : assert property (@(posedge clock) disable iff (reset)
      busy |-> !mem_we)
      else $error("store written during a search");

   a_drain_responds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) && pipe_empty |=> rsp_valid_ff && rsp_data_ff.found && !busy)
      else $error("search finished without a response");

   a_scan_has_points : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff != '0) && (CNT_W'(scan_pt_ff) < count_ff))
      else $error("scan index outside stored points");

endmodule

`default_nettype wire
